>>> src/mm_pkg.sv
// Shared types and codes of the matrix multiply core.
`default_nettype none
package mm_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned ROW_W  = 3;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

  // Request kinds
  localparam logic [1:0] KIND_WRITE_A = 2'd0;
  localparam logic [1:0] KIND_WRITE_B = 2'd1;
  localparam logic [1:0] KIND_COMPUTE = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_A_COLS = 2'd1;
  localparam logic [1:0] CFG_B_ROWS = 2'd2;
  localparam logic [1:0] CFG_B_COLS = 2'd3;

  // Tag that travels with each operand pair through the multiply-accumulate unit
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm_tag_t;

endpackage
`default_nettype wire

>>> src/matrix_multiply_core.sv
// Top level of the matrix multiply core: sequencer, element stores and result register.
//
// Write requests (kind 0 for A, 1 for B) store one Q16.16 element each; writes with a
// row or column at or above MAX_DIM are dropped. A compute request walks C = A x B in
// row-major order through one shared multiply-accumulate unit, one product term per
// cycle. Each element of C passes through address issue per term, then the store read,
// multiply and accumulate stages, then the result load, which waits while the result
// register is held by the consumer. The full sum is shifted down by FRAC_BITS and
// saturated to 32 bits. A zero dimension counts as 1 and one above MAX_DIM as MAX_DIM;
// when a_cols differs from b_rows after this clamping a single result with dim_error
// set is given. in_ready is low for the whole of a compute. Elements must be written
// before they are read; the stores have no reset.
`default_nettype none
module matrix_multiply_core #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       kind_i,
  input  wire logic [mm_pkg::ROW_W-1:0]         row_index_i,
  input  wire logic [mm_pkg::ROW_W-1:0]         col_index_i,
  input  wire logic signed [mm_pkg::ELEM_W-1:0] element_i,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mm_pkg::ROW_W-1:0]              out_row_o,
  output logic [mm_pkg::ROW_W-1:0]              out_col_o,
  output logic signed [mm_pkg::ELEM_W-1:0]      out_value_o,
  output logic                                  last_o,
  output logic                                  dim_error_o,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [mm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned ACC_W  = 2 * mm_pkg::ELEM_W + $clog2(MAX_DIM) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_EMIT,
    ST_ERROR
  } state_e;

  state_e state_q;

  logic [mm_pkg::CFG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [IDX_W-1:0] r_q, c_q, k_q;
  logic [IDX_W-1:0] r_last_q, k_last_q, c_last_q;
  logic [IDX_W-1:0] ar_last, ac_last, br_last, bc_last;

  mm_pkg::mm_tag_t tag_q;
  mm_pkg::mm_tag_t tag_d;

  logic in_fire, wr_ok, we_a, we_b, slot_free, elem_last, emit;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [mm_pkg::ELEM_W-1:0] rdata_a, rdata_b;
  logic mac_done;
  logic signed [mm_pkg::ELEM_W-1:0] mac_result;

  function automatic logic [IDX_W-1:0] last_idx(input logic [mm_pkg::CFG_W-1:0] d);
    if (d == '0) begin
      return '0;
    end else if ({1'b0, d} > 5'(MAX_DIM)) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(d - 4'd1);
    end
  endfunction

  assign ar_last = last_idx(a_rows_q);
  assign ac_last = last_idx(a_cols_q);
  assign br_last = last_idx(b_rows_q);
  assign bc_last = last_idx(b_cols_q);

  assign in_ready  = (state_q == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign elem_last = (r_q == r_last_q) && (c_q == c_last_q);
  assign emit      = slot_free && ((state_q == ST_EMIT) || (state_q == ST_ERROR));

  assign wr_ok = ({2'b0, row_index_i} < 5'(MAX_DIM)) && ({2'b0, col_index_i} < 5'(MAX_DIM));
  assign we_a  = in_fire && (kind_i == mm_pkg::KIND_WRITE_A) && wr_ok;
  assign we_b  = in_fire && (kind_i == mm_pkg::KIND_WRITE_B) && wr_ok;
  assign waddr = ADDR_W'(ADDR_W'(row_index_i) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index_i));

  assign raddr_a = ADDR_W'(ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
  assign raddr_b = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q));

  // one product term per cycle for the current element
  always_comb begin
    tag_d = '0;
    if (state_q == ST_ISSUE) begin
      tag_d.valid = 1'b1;
      tag_d.first = (k_q == '0);
      tag_d.last  = (k_q == k_last_q);
    end
  end

  mm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mm_mac #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (tag_q),
    .a_i      (rdata_a),
    .b_i      (rdata_b),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= mm_pkg::CFG_DIM_RESET;
      a_cols_q <= mm_pkg::CFG_DIM_RESET;
      b_rows_q <= mm_pkg::CFG_DIM_RESET;
      b_cols_q <= mm_pkg::CFG_DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mm_pkg::CFG_A_ROWS: a_rows_q <= cfg_data;
        mm_pkg::CFG_A_COLS: a_cols_q <= cfg_data;
        mm_pkg::CFG_B_ROWS: b_rows_q <= cfg_data;
        mm_pkg::CFG_B_COLS: b_cols_q <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid   <= 1'b0;
      tag_q       <= '0;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      r_last_q    <= '0;
      k_last_q    <= '0;
      c_last_q    <= '0;
      out_row_o   <= '0;
      out_col_o   <= '0;
      out_value_o <= '0;
      last_o      <= 1'b0;
      dim_error_o <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      tag_q <= tag_d;
      case (state_q)
        ST_IDLE: begin
          if (in_fire && (kind_i == mm_pkg::KIND_COMPUTE)) begin
            r_q      <= '0;
            c_q      <= '0;
            k_q      <= '0;
            r_last_q <= ar_last;
            k_last_q <= ac_last;
            c_last_q <= bc_last;
            state_q  <= (ac_last != br_last) ? ST_ERROR : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (k_q == k_last_q) begin
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (mac_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_row_o   <= mm_pkg::ROW_W'(r_q);
            out_col_o   <= mm_pkg::ROW_W'(c_q);
            out_value_o <= mac_result;
            last_o      <= elem_last;
            dim_error_o <= 1'b0;
            k_q         <= '0;
            if (elem_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_ISSUE;
              if (c_q == c_last_q) begin
                c_q <= '0;
                r_q <= r_q + 1'b1;
              end else begin
                c_q <= c_q + 1'b1;
              end
            end
          end
        end
        ST_ERROR: begin
          if (slot_free) begin
            out_row_o   <= '0;
            out_col_o   <= '0;
            out_value_o <= '0;
            last_o      <= 1'b1;
            dim_error_o <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/mm_store.sv
// Element store: one write port, one registered read port.
`default_nettype none
module mm_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [ADDR_W-1:0]         waddr_i,
  input  wire logic [mm_pkg::ELEM_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0]         raddr_i,
  output logic      [mm_pkg::ELEM_W-1:0] rdata_o
);

  logic [mm_pkg::ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> src/mm_mac.sv
// Shared multiply-accumulate unit with scale-down and saturation of the sum.
`default_nettype none
module mm_mac #(
  parameter int unsigned ACC_W     = 67,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mm_pkg::mm_tag_t                  tag_i,
  input  wire logic signed [mm_pkg::ELEM_W-1:0] a_i,
  input  wire logic signed [mm_pkg::ELEM_W-1:0] b_i,
  output logic                                  done_o,
  output logic signed [mm_pkg::ELEM_W-1:0]      result_o
);

  localparam int unsigned PROD_W = 2 * mm_pkg::ELEM_W;

  mm_pkg::mm_tag_t          p_tag_q;
  logic                     done_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  scaled;
  logic [ACC_W-mm_pkg::ELEM_W:0] upper;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_tag_q <= '0;
      done_q  <= 1'b0;
    end else begin
      p_tag_q <= tag_i;
      done_q  <= p_tag_q.valid & p_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_i.valid) begin
      prod_q <= a_i * b_i;
    end
    if (p_tag_q.valid) begin
      // restart the sum on the first term of each inner product
      acc_q <= p_tag_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
    end
  end

  assign scaled = acc_q >>> FRAC_BITS;
  assign upper  = scaled[ACC_W-1:mm_pkg::ELEM_W-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      result_o = scaled[mm_pkg::ELEM_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      result_o = {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire
